// ----- hdl/psched_pkg.sv -----
package psched_pkg;

  localparam int MAX_TASKS     = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int ID_BITS       = $clog2(MAX_TASKS);
  localparam int CNT_BITS      = $clog2(MAX_TASKS + 1);
  localparam int INDEX_W       = 4;

  typedef logic [ID_BITS-1:0]       id_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;
  typedef logic [PRIORITY_BITS-1:0] prio_t;

  typedef enum logic [1:0] {
    SLOT_UNUSED     = 2'd0,
    SLOT_READY      = 2'd1,
    SLOT_RUNNING    = 2'd2,
    SLOT_TERMINATED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    OP_CREATE    = 2'd0,
    OP_SCHEDULE  = 2'd1,
    OP_TERMINATE = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_TASKS   = 2'd1,
    STAT_POOL_FULL  = 2'd2,
    STAT_NO_CURRENT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_EXEC   = 2'd1,
    S_SCAN   = 2'd2,
    S_RESULT = 2'd3
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic commit;
  } psched_cmd_t;

  typedef struct packed {
    logic no_op;
    logic need_scan;
    logic scan_last;
    logic out_free;
  } psched_sts_t;

endpackage

// ----- hdl/psched_ctrl.sv -----
module psched_ctrl import psched_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  psched_sts_t sts,
  output psched_cmd_t cmd
);

  fsm_state_t state;
  fsm_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.no_op)     state_next = S_IDLE;
        else if (sts.need_scan)     state_next = S_SCAN;
        else                        state_next = S_RESULT;
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EXEC:   cmd.exec   = 1'b1;
      S_SCAN:   cmd.step   = 1'b1;
      S_RESULT: cmd.commit = sts.out_free;
      default: begin
        cmd      = '0;
        in_stall = 1'b1;
      end
    endcase
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) cmd.commit |-> sts.out_free)
    else $error("commit while result register is occupied");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> cmd.exec)
    else $error("accepted word not executed");
  assert property (@(posedge clk) disable iff (rst) (cmd.step && sts.scan_last) |=> !cmd.step)
    else $error("scan ran past last slot");
`endif

endmodule

// ----- hdl/psched_dp.sv -----
module psched_dp import psched_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  psched_cmd_t         cmd,
  output psched_sts_t         sts,
  input  logic [1:0]          op,
  input  logic [7:0]          new_prio,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [INDEX_W-1:0]  task_id,
  output logic                index_valid,
  output logic [1:0]          status_code,
  output logic                all_done
);

  slot_state_t slot_state [MAX_TASKS];
  prio_t       slot_priority [MAX_TASKS];
  cnt_t        created_count;
  cnt_t        term_count;
  id_t         current_task;
  logic        current_valid;

  op_t   op_q;
  prio_t prio_q;
  logic  bad_term;

  id_t   scan_idx;
  logic  found;
  prio_t best_prio;
  id_t   best_id;

  logic               create_ok;
  cnt_t               created_next;
  logic [INDEX_W-1:0] res_index;
  logic               res_ivalid;
  status_t            res_status;

  assign create_ok = created_count < CNT_BITS'(MAX_TASKS);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= op_t'(op);
      prio_q <= PRIORITY_BITS'(new_prio);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      bad_term  <= (op_q == OP_TERMINATE) && !current_valid;
      scan_idx  <= '0;
      found     <= 1'b0;
      best_prio <= '0;
      best_id   <= '0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + 1'b1;
      if (slot_state[scan_idx] == SLOT_READY &&
          (!found || slot_priority[scan_idx] > best_prio)) begin
        found     <= 1'b1;
        best_prio <= slot_priority[scan_idx];
        best_id   <= scan_idx;
      end
    end
  end

  always_comb begin
    res_index    = '0;
    res_ivalid   = 1'b0;
    res_status   = STAT_OK;
    created_next = created_count;
    priority if (op_q == OP_CREATE) begin
      if (create_ok) begin
        res_index    = INDEX_W'(created_count);
        res_ivalid   = 1'b1;
        created_next = created_count + 1'b1;
      end else begin
        res_status = STAT_POOL_FULL;
      end
    end else if (op_q == OP_TERMINATE && bad_term) begin
      res_status = STAT_NO_CURRENT;
    end else if (found) begin
      res_index  = INDEX_W'(best_id);
      res_ivalid = 1'b1;
    end else begin
      res_status = STAT_NO_TASKS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TASKS; i++) slot_state[i] <= SLOT_UNUSED;
      created_count <= '0;
      term_count    <= '0;
      current_task  <= '0;
      current_valid <= 1'b0;
    end else begin
      if (cmd.exec && op_q == OP_TERMINATE && current_valid) begin
        slot_state[current_task] <= SLOT_TERMINATED;
        term_count               <= term_count + 1'b1;
        current_valid            <= 1'b0;
      end
      if (cmd.commit) begin
        if (op_q == OP_CREATE) begin
          if (create_ok) begin
            slot_state[created_count[ID_BITS-1:0]] <= SLOT_READY;
            created_count                          <= created_next;
          end
        end else if (!bad_term && found) begin
          slot_state[best_id] <= SLOT_RUNNING;
          current_task        <= best_id;
          current_valid       <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && op_q == OP_CREATE && create_ok) begin
      slot_priority[created_count[ID_BITS-1:0]] <= prio_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      task_id     <= res_index;
      index_valid <= res_ivalid;
      status_code <= res_status;
      all_done    <= (term_count == created_next);
    end
  end

  assign sts.no_op     = (op_q == OP_NONE);
  assign sts.need_scan = (op_q == OP_SCHEDULE) || (op_q == OP_TERMINATE && current_valid);
  assign sts.scan_last = (scan_idx == ID_BITS'(MAX_TASKS - 1));
  assign sts.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) term_count <= created_count)
    else $error("more terminated tasks than created");
  assert property (@(posedge clk) disable iff (rst)
      current_valid |-> slot_state[current_task] == SLOT_RUNNING)
    else $error("current task not running");
  assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (index_valid == (status_code == STAT_OK)))
    else $error("index valid disagrees with status");
  assert property (@(posedge clk) disable iff (rst) created_count <= CNT_BITS'(MAX_TASKS))
    else $error("created count overflow");
`endif

endmodule

// ----- hdl/priority_task_scheduler_unit.sv -----
// Create, and terminate with no current task: the accepted word goes from EXEC
// to RESULT with no scan. Schedule and terminate scan the MAX_TASKS slots, one
// slot per cycle, for the best ready task; RESULT holds until the output is free.
// One word in work at a time: a new word is taken only once the last has left
// RESULT; the next is accepted while a result word waits.
// Synchronous active-high reset: all slots unused, counts zero, no current task.
module priority_task_scheduler_unit import psched_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [7:0]         new_prio,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [INDEX_W-1:0] task_id,
  output logic               index_valid,
  output logic [1:0]         status_code,
  output logic               all_done
);

  psched_cmd_t cmd;
  psched_sts_t sts;

  psched_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  psched_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .new_prio      (new_prio),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .task_id       (task_id),
    .index_valid   (index_valid),
    .status_code   (status_code),
    .all_done      (all_done)
  );

endmodule
